@@ hw/rtl/highpass_integrate_velocity_core_macros.svh @@
// ----------------------------------------------------------------------------
// highpass_integrate_velocity_core_macros
// assertion macros for the high-pass velocity integrator
// ----------------------------------------------------------------------------
`ifndef HIGHPASS_INTEGRATE_VELOCITY_CORE_MACROS_SVH
`define HIGHPASS_INTEGRATE_VELOCITY_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on clk, quiet during rst
`define HIVEL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hivel: implication check failed");

// next-cycle implication, checked on clk, quiet during rst
`define HIVEL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hivel: next-cycle check failed");

`else

`define HIVEL_ASSERT_IMPL(label, ante, cons)
`define HIVEL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hw/rtl/hivel_pkg.sv @@
// ----------------------------------------------------------------------------
// hivel_pkg
// shared types, codes and saturation helpers for the velocity integrator
// ----------------------------------------------------------------------------
`default_nettype none

package hivel_pkg;

  localparam int DATA_W   = 32;
  localparam int COEF_W   = 16;
  localparam int CNT_W    = 16;
  localparam int OPND_W   = DATA_W + 1;
  localparam int PROD_W   = 2 * OPND_W;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_ALPHA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_THR   = 2'd2;

  localparam logic [COEF_W-1:0] ACCEL_ALPHA_RST = 16'd3277;
  localparam logic [COEF_W-1:0] VEL_ALPHA_RST   = 16'd1638;
  localparam logic [COEF_W-1:0] STILL_THR_RST   = 16'd3277;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic signed [PROD_W-1:0] SAT_HI  = 66'sh0_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] SAT_LO  = -66'sh0_8000_0000;
  localparam logic signed [PROD_W-1:0] RND_HALF = 66'sd32768;

  typedef enum logic [3:0] {
    S_IDLE,
    S_THR,
    S_LP_MUL,
    S_LP_ADD,
    S_HP,
    S_INT,
    S_VL_MUL,
    S_VL_ADD,
    S_OUT,
    S_FIN
  } hivel_state_t;

  // request to the shared multiplier
  typedef struct packed {
    logic              en;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } mul_req_t;

  function automatic logic signed [PROD_W-1:0] sx66(input logic [DATA_W-1:0] v);
    sx66 = {{(PROD_W - DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > SAT_HI) begin
      sat32 = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      sat32 = SAT_LO[DATA_W-1:0];
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hivel_mul.sv @@
// ----------------------------------------------------------------------------
// hivel_mul
// shared signed 33x33 multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module hivel_mul (
  input  wire logic                                 clk,
  input  wire hivel_pkg::mul_req_t                  req,
  output logic signed [hivel_pkg::PROD_W-1:0]       prod
);
  import hivel_pkg::*;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= $signed(req.a) * $signed(req.b);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/highpass_integrate_velocity_core.sv @@
// ----------------------------------------------------------------------------
// highpass_integrate_velocity_core
// three-axis leaky high-pass trapezoidal integrator, signed Q16.16
// ----------------------------------------------------------------------------
// usage:
//   input beat: sample_x/y/z, taken when in_valid is high and in_stall low.
//   output beat: vel_x/y/z and still_count, taken when out_valid is high and
//   out_stall low. config writes go over cfg_valid/cfg_ready with cfg_index
//   and cfg_data; cfg_ready is always high, index 3 is ignored.
//   one sample is worked through a single shared 33x33 multiplier: first the
//   stillness threshold is squared, then each axis runs its low-pass multiply,
//   low-pass add, high-pass, integrate, velocity multiply, velocity add and
//   output steps (two low-pass updates and the square of its high-pass all go
//   through the multiplier), then the result is published.
//   a new sample is taken only once the last one is through: in_stall is high
//   while a sample is being worked on.
//   the result sits in an output register, so the next sample is accepted
//   while it waits; if the receiver still stalls when the next result is
//   done, the block holds in its publish step until the old beat is taken.
//   reset (rst, synchronous) restores the coefficients, clears all filter
//   state and the stillness counter, and marks the next sample as the first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "highpass_integrate_velocity_core_macros.svh"

module highpass_integrate_velocity_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [hivel_pkg::DATA_W-1:0]   sample_x,
  input  wire logic signed [hivel_pkg::DATA_W-1:0]   sample_y,
  input  wire logic signed [hivel_pkg::DATA_W-1:0]   sample_z,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [hivel_pkg::DATA_W-1:0]        vel_x,
  output logic signed [hivel_pkg::DATA_W-1:0]        vel_y,
  output logic signed [hivel_pkg::DATA_W-1:0]        vel_z,
  output logic        [hivel_pkg::CNT_W-1:0]         still_count,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic   [hivel_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic   [hivel_pkg::COEF_W-1:0]        cfg_data
);
  import hivel_pkg::*;

  hivel_state_t state;
  hivel_state_t state_next;

  logic [COEF_W-1:0] accel_alpha;
  logic [COEF_W-1:0] vel_alpha;
  logic [COEF_W-1:0] still_threshold;

  logic              first_pending;
  logic [AXIS_W-1:0] axis;
  logic [DATA_W-1:0] smp      [NUM_AXES];
  logic [DATA_W-1:0] lp       [NUM_AXES];
  logic [DATA_W-1:0] prev_hp  [NUM_AXES];
  logic [DATA_W-1:0] isum     [NUM_AXES];
  logic [DATA_W-1:0] lp_isum  [NUM_AXES];
  logic [DATA_W-1:0] vel_new  [NUM_AXES];
  logic [DATA_W-1:0] hp;
  logic [CNT_W-1:0]  still_counter;
  logic signed [PROD_W-1:0] mag;

  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;

  logic                     fin_load;
  logic signed [PROD_W-1:0] rnd;
  logic [DATA_W-1:0]        lp_base;
  logic [DATA_W-1:0]        lp_upd;
  logic [OPND_W-1:0]        half;

  hivel_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign fin_load  = (state == S_FIN) && (!out_valid || !out_stall);

  // shared low-pass adder: base + round(prod / 2^16)
  assign rnd     = (prod + RND_HALF) >>> 16;
  assign lp_base = (state == S_VL_ADD) ? lp_isum[axis] : lp[axis];
  assign lp_upd  = sat32(sx66(lp_base) + rnd);
  assign half    = ($signed({prev_hp[axis][DATA_W-1], prev_hp[axis]}) +
                    $signed({hp[DATA_W-1], hp})) >>> 1;

  always_comb begin
    mul_req = '0;
    unique case (state)
      S_THR: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(OPND_W - COEF_W){1'b0}}, still_threshold};
        mul_req.b  = {{(OPND_W - COEF_W){1'b0}}, still_threshold};
      end
      S_LP_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = {smp[axis][DATA_W-1], smp[axis]} - {lp[axis][DATA_W-1], lp[axis]};
        mul_req.b  = {{(OPND_W - COEF_W){1'b0}}, accel_alpha};
      end
      S_INT: begin
        mul_req.en = 1'b1;
        mul_req.a  = {hp[DATA_W-1], hp};
        mul_req.b  = {hp[DATA_W-1], hp};
      end
      S_VL_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = {isum[axis][DATA_W-1], isum[axis]} -
                     {lp_isum[axis][DATA_W-1], lp_isum[axis]};
        mul_req.b  = {{(OPND_W - COEF_W){1'b0}}, vel_alpha};
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_THR;
      S_THR:    state_next = S_LP_MUL;
      S_LP_MUL: state_next = S_LP_ADD;
      S_LP_ADD: state_next = S_HP;
      S_HP:     state_next = S_INT;
      S_INT:    state_next = S_VL_MUL;
      S_VL_MUL: state_next = S_VL_ADD;
      S_VL_ADD: state_next = S_OUT;
      S_OUT:    state_next = (axis == AXIS_W'(NUM_AXES - 1)) ? S_FIN : S_LP_MUL;
      S_FIN:    if (fin_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_alpha     <= ACCEL_ALPHA_RST;
      vel_alpha       <= VEL_ALPHA_RST;
      still_threshold <= STILL_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACCEL_ALPHA: accel_alpha     <= cfg_data;
        CFG_VEL_ALPHA:   vel_alpha       <= cfg_data;
        CFG_STILL_THR:   still_threshold <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      axis          <= '0;
      still_counter <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        lp[i]      <= '0;
        prev_hp[i] <= '0;
        isum[i]    <= '0;
        lp_isum[i] <= '0;
      end
    end else begin
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            smp[0] <= sample_x;
            smp[1] <= sample_y;
            smp[2] <= sample_z;
            axis   <= '0;
            // first beat seeds the low-pass, so its high-pass comes out zero
            if (first_pending) begin
              first_pending <= 1'b0;
              lp[0]      <= sample_x;
              lp[1]      <= sample_y;
              lp[2]      <= sample_z;
              for (int i = 0; i < NUM_AXES; i++) begin
                prev_hp[i] <= '0;
              end
            end
          end
        end
        S_LP_MUL: begin
          // prod holds threshold squared here; magnitude counts down from it
          if (axis == '0) begin
            mag <= prod;
          end
        end
        S_LP_ADD: begin
          lp[axis] <= lp_upd;
        end
        S_HP: begin
          hp <= sat32(sx66(smp[axis]) - sx66(lp[axis]));
        end
        S_INT: begin
          isum[axis]    <= sat32(sx66(isum[axis]) +
                                 {{(PROD_W - OPND_W){half[OPND_W-1]}}, half});
          prev_hp[axis] <= hp;
        end
        S_VL_MUL: begin
          mag <= mag - prod;
        end
        S_VL_ADD: begin
          lp_isum[axis] <= lp_upd;
        end
        S_OUT: begin
          vel_new[axis] <= sat32(sx66(isum[axis]) - sx66(lp_isum[axis]));
          if (axis != AXIS_W'(NUM_AXES - 1)) begin
            axis <= axis + 1'b1;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            vel_x <= vel_new[0];
            vel_y <= vel_new[1];
            vel_z <= vel_new[2];
            // still when threshold^2 minus the squared magnitude stays positive
            if (mag > 0) begin
              if (still_counter != CNT_MAX) begin
                still_counter <= still_counter + 1'b1;
                still_count   <= still_counter + 1'b1;
              end else begin
                still_count <= still_counter;
              end
            end else begin
              still_counter <= '0;
              still_count   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `HIVEL_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall)
  `HIVEL_ASSERT_IMPL(a_axis_range, state != S_IDLE, axis != 2'd3)
  `HIVEL_ASSERT_NEXT(a_fin_holds, state == S_FIN && out_valid && out_stall, state == S_FIN)
  `HIVEL_ASSERT_NEXT(a_out_holds, out_valid && out_stall, $stable(vel_x) && $stable(still_count))

endmodule

`default_nettype wire

@@ tb/sv/highpass_integrate_velocity_core_test.sv @@
// ----------------------------------------------------------------------------
// highpass_integrate_velocity_core_test
// self-checking bench for the three-axis high-pass velocity integrator
// ----------------------------------------------------------------------------
// a short table of directed beats and register writes comes first, then
// random phases of still, moving, wild and edge-valued sample runs under
// several coefficient settings and idle patterns. every output beat is
// compared field by field with a table beat or a bit-true Q16.16 velocity predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module highpass_integrate_velocity_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hivel_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 229;
  localparam int N_DIRECTED      = 27;
  localparam int TAIL_CYCLES     = 40;

  // index past the register list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;

  typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_e;
  typedef enum int {SEG_STILL, SEG_MOVE, SEG_WILD, SEG_EDGE} seg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] vz;
    logic        [CNT_W-1:0]  cnt;
  } vel_beat_t;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [COEF_W-1:0]        reg_val;
    logic signed [DATA_W-1:0] sx;
    logic signed [DATA_W-1:0] sy;
    logic signed [DATA_W-1:0] sz;
    bit                       known;
    vel_beat_t                beat;
  } directed_row_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [DATA_W-1:0]   sample_x = '0;
  logic signed [DATA_W-1:0]   sample_y = '0;
  logic signed [DATA_W-1:0]   sample_z = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [DATA_W-1:0]   vel_x;
  logic signed [DATA_W-1:0]   vel_y;
  logic signed [DATA_W-1:0]   vel_z;
  logic        [CNT_W-1:0]    still_count;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [COEF_W-1:0]          cfg_data = '0;

  highpass_integrate_velocity_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_x    (sample_x),
    .sample_y    (sample_y),
    .sample_z    (sample_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .vel_z       (vel_z),
    .still_count (still_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor copy of the registers and filter state
  longint      accel_coef = longint'(ACCEL_ALPHA_RST);
  longint      vel_coef   = longint'(VEL_ALPHA_RST);
  longint      still_thr  = longint'(STILL_THR_RST);
  bit          first_sample = 1'b1;
  longint      lp_acc [NUM_AXES];
  longint      prev_hp [NUM_AXES];
  longint      int_sum [NUM_AXES];
  longint      lp_int [NUM_AXES];
  int unsigned still_run = 0;

  vel_beat_t   pending_vel [$];
  vel_beat_t   seen_beat;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;

  function automatic longint clamp_q16(input longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  function automatic longint smooth(input longint lp, input longint x, input longint coef);
    longint prod;
    prod = (x - lp) * coef + 64'sd32768;
    return clamp_q16(lp + (prod >>> 16));
  endfunction

  function automatic vel_beat_t predict_velocity(input logic signed [DATA_W-1:0] sx,
                                                 input logic signed [DATA_W-1:0] sy,
                                                 input logic signed [DATA_W-1:0] sz);
    longint                   smp [NUM_AXES];
    logic signed [DATA_W-1:0] vel [NUM_AXES];
    longint                   hp;
    longint unsigned          mag2;
    vel_beat_t                beat;
    smp[0] = longint'(sx);
    smp[1] = longint'(sy);
    smp[2] = longint'(sz);
    mag2 = 0;
    // first beat after reset seeds the low-pass so its high-pass is zero
    if (first_sample) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        lp_acc[a] = smp[a];
        prev_hp[a] = 0;
      end
      first_sample = 1'b0;
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      lp_acc[a] = smooth(lp_acc[a], smp[a], accel_coef);
      hp = clamp_q16(smp[a] - lp_acc[a]);
      int_sum[a] = clamp_q16(int_sum[a] + ((prev_hp[a] + hp) >>> 1));
      prev_hp[a] = hp;
      mag2 += longint'(hp * hp);
    end
    if (mag2 < longint'(still_thr * still_thr)) begin
      if (still_run < 65535) still_run++;
    end else begin
      still_run = 0;
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      lp_int[a] = smooth(lp_int[a], int_sum[a], vel_coef);
      vel[a] = DATA_W'(clamp_q16(int_sum[a] - lp_int[a]));
    end
    beat.vx = vel[0];
    beat.vy = vel[1];
    beat.vz = vel[2];
    beat.cnt = still_run[CNT_W-1:0];
    return beat;
  endfunction

  function automatic directed_row_t smp_row(input logic signed [DATA_W-1:0] x,
                                            input logic signed [DATA_W-1:0] y,
                                            input logic signed [DATA_W-1:0] z);
    directed_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.sx = x;
    r.sy = y;
    r.sz = z;
    return r;
  endfunction

  function automatic directed_row_t known_row(input logic signed [DATA_W-1:0] x,
                                              input logic signed [DATA_W-1:0] y,
                                              input logic signed [DATA_W-1:0] z,
                                              input vel_beat_t beat);
    directed_row_t r;
    r = smp_row(x, y, z);
    r.known = 1'b1;
    r.beat = beat;
    return r;
  endfunction

  function automatic directed_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [COEF_W-1:0] val);
    directed_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] pick_reg_value(input bit is_thr);
    case ($urandom_range(9))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3, 4: return 16'($urandom);
      default: return is_thr ? 16'($urandom_range(200, 20000)) : 16'($urandom_range(100, 8000));
    endcase
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ACCEL_ALPHA: accel_coef = longint'(val);
      CFG_VEL_ALPHA:   vel_coef = longint'(val);
      CFG_STILL_THR:   still_thr = longint'(val);
      default: ;
    endcase
  endtask

  task automatic push_sample(input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] y,
                             input logic signed [DATA_W-1:0] z,
                             input bit known, input vel_beat_t known_beat);
    vel_beat_t beat;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_x <= x;
    sample_y <= y;
    sample_z <= z;
    do @(posedge clk); while (in_stall);
    beat = predict_velocity(x, y, z);
    pending_vel.push_back(known ? known_beat : beat);
  endtask

  // drop valid and hold off until every outstanding beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_vel.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("highpass_integrate_velocity_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_vel.size() == 0) begin
        $error("unexpected output beat: vel_x %0d vel_y %0d vel_z %0d still_count %0d",
               vel_x, vel_y, vel_z, still_count);
        fail_count++;
      end else begin
        seen_beat = pending_vel.pop_front();
        check_field("vel_x", 64'(seen_beat.vx), 64'(vel_x));
        check_field("vel_y", 64'(seen_beat.vy), 64'(vel_y));
        check_field("vel_z", 64'(seen_beat.vz), 64'(vel_z));
        check_field("still_count", 64'(seen_beat.cnt), 64'(still_count));
      end
    end
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  directed_row_t directed_rows [N_DIRECTED];

  initial begin
    int                       seg_left;
    seg_e                     seg_mode;
    longint                   noise_amp;
    longint                   v;
    longint                   base [NUM_AXES];
    longint                   drift [NUM_AXES];
    logic signed [DATA_W-1:0] axis_val [NUM_AXES];
    vel_beat_t                no_beat;

    seg_left = 0;
    seg_mode = SEG_STILL;
    noise_amp = 0;
    no_beat = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      base[a] = 0;
      drift[a] = 0;
    end

    directed_rows = '{
      known_row(Q_MAX, Q_MIN, 32'sd0, vel_beat_t'{32'sd0, 32'sd0, 32'sd0, 16'd1}),
      known_row(Q_MAX, Q_MIN, 32'sd0, vel_beat_t'{32'sd0, 32'sd0, 32'sd0, 16'd2}),
      smp_row(Q_MIN, Q_MAX, -32'sd1),
      smp_row(Q_MIN, Q_MAX, -32'sd1),
      smp_row(32'sd0, 32'sd0, 32'sd0),
      smp_row(32'sd1, -32'sd1, 32'sh0001_0000),
      cfg_row(CFG_STILL_THR, 16'd0),
      smp_row(32'sd0, 32'sd0, 32'sd0),
      smp_row(32'sd0, 32'sd0, 32'sd0),
      cfg_row(CFG_ACCEL_ALPHA, 16'd0),
      smp_row(32'sh1234_5678, -32'sd4660, 32'sd7),
      smp_row(Q_MAX, Q_MAX, Q_MAX),
      cfg_row(CFG_VEL_ALPHA, 16'd0),
      smp_row(Q_MIN, Q_MIN, Q_MIN),
      smp_row(32'sd5, 32'sd5, 32'sd5),
      cfg_row(CFG_ACCEL_ALPHA, 16'hFFFF),
      cfg_row(CFG_VEL_ALPHA, 16'hFFFF),
      cfg_row(CFG_STILL_THR, 16'hFFFF),
      smp_row(Q_MAX, 32'sd0, Q_MIN),
      smp_row(32'sd100, 32'sd100, 32'sd100),
      smp_row(32'sd100, 32'sd100, 32'sd100),
      cfg_row(CFG_SPARE, 16'hA5A5),
      cfg_row(CFG_ACCEL_ALPHA, 16'd1),
      cfg_row(CFG_VEL_ALPHA, 16'd1),
      smp_row(-32'sd65536, 32'sd65536, 32'sd0),
      smp_row(Q_MIN, Q_MIN, Q_MAX),
      smp_row(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        push_sample(directed_rows[i].sx, directed_rows[i].sy, directed_rows[i].sz,
                    directed_rows[i].known, directed_rows[i].beat);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      write_reg(CFG_ACCEL_ALPHA, pick_reg_value(1'b0));
      write_reg(CFG_VEL_ALPHA, pick_reg_value(1'b0));
      write_reg(CFG_STILL_THR, pick_reg_value(1'b1));
      case (ph % 4)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 57;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 57;
        end
        default: begin
          in_idle_pct = 13;
          out_stall_pct = 13;
        end
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (seg_left == 0) begin
          case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7: seg_mode = SEG_STILL;
            8, 9, 10, 11, 12, 13, 14: seg_mode = SEG_MOVE;
            15, 16, 17: seg_mode = SEG_WILD;
            default: seg_mode = SEG_EDGE;
          endcase
          seg_left = $urandom_range(4, 40);
          noise_amp = longint'($urandom_range(2000));
          for (int a = 0; a < NUM_AXES; a++) begin
            drift[a] = longint'($urandom_range(200000)) - 100000;
            if ($urandom_range(1) == 0)
              base[a] = longint'($urandom_range(1 << 25)) - (1 << 24);
          end
        end
        seg_left--;

        for (int a = 0; a < NUM_AXES; a++) begin
          case (seg_mode)
            SEG_WILD: v = longint'(signed'($urandom));
            SEG_EDGE: begin
              case ($urandom_range(4))
                0: v = SAT_MIN;
                1: v = SAT_MAX;
                2: v = 0;
                3: v = -1;
                default: v = 1;
              endcase
            end
            default: begin
              if (seg_mode == SEG_MOVE) begin
                base[a] = base[a] + drift[a];
                if (base[a] > (64'sd1 <<< 30) || base[a] < -(64'sd1 <<< 30))
                  drift[a] = -drift[a];
              end
              v = base[a] + longint'($urandom_range(32'(2 * noise_amp))) - noise_amp;
            end
          endcase
          axis_val[a] = DATA_W'(clamp_q16(v));
        end

        push_sample(axis_val[0], axis_val[1], axis_val[2], 1'b0, no_beat);
        // now and then let the pipeline run dry mid-phase
        if ($urandom_range(99) == 0) settle();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("highpass_integrate_velocity_core: match");
    end else begin
      $display("highpass_integrate_velocity_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
